// File: sv/slc_pkg.sv
`timescale 1ns / 1ps

package slc_pkg;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NACK  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [7:0]  MAX_TRIES_RST = 8'd10;
  localparam logic [7:0]  MAX_NACK_RST  = 8'd5;

  localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
  localparam logic [7:0]  FAILS_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_POLL = 2'd0,
    OP_ENQ  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Received frame header codes.
  localparam logic [2:0] HDR_CONFIG = 3'd2;
  localparam logic [2:0] HDR_FLAGS  = 3'd3;

  // Message types that are retried.
  localparam logic [1:0] MSG_ALARM  = 2'd1;
  localparam logic [1:0] MSG_CONFIG = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ACK    = 3'd1,
    ACT_NACK   = 3'd2,
    ACT_SEND   = 3'd3,
    ACT_RESEND = 3'd4
  } link_act_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ms_tick;
    logic       frame_ready;
    logic       frame_valid;
    logic [2:0] frame_header;
    logic [7:0] frame_length;
    logic       flag_is_ack;
    logic [1:0] msg_type;
    logic [7:0] msg_length;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    link_act_t  link_action;
    logic [1:0] link_type;
    logic [2:0] link_slot;
    logic [7:0] link_length;
    logic       rx_store;
    logic [2:0] rx_slot;
    logic [1:0] rx_type;
    logic [7:0] rx_length;
    logic [2:0] enq_slot;
  } out_word_t;

  // Transmit queue entry.
  typedef struct packed {
    logic       sent;
    logic       retry;
    logic [7:0] fails;
    logic [1:0] msg_type;
    logic [7:0] len;
  } tx_entry_t;

  // Receive queue entry.
  typedef struct packed {
    logic [1:0] msg_type;
    logic [7:0] len;
  } rx_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

endpackage

// File: sv/slc_if.sv
`timescale 1ns / 1ps

interface slc_in_if;
  logic             valid;
  logic             ready;
  slc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slc_out_if;
  logic              valid;
  logic              ready;
  slc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/stop_and_wait_link_controller.sv
`timescale 1ns / 1ps

// Stop-and-wait link controller. Each word on the input channel is one
// operation: poll the link, enqueue a transmit message, or read a received
// message; each produces exactly one result word. A word is first registered
// and then run against the queue state, which loads the result register. The
// next word is taken as soon as that step is done, even while the result still
// waits to be taken, but not before the last word has run; a result that is
// not taken holds the following word in its execute cycle. Payload bytes are
// not moved by this block: results name the transmit or receive slot, and the
// user copies the bytes in external memory. Configuration writes are taken at any
// time on cfg_we and must only be issued while no word is in flight.

module stop_and_wait_link_controller #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  slc_in_if.sink                          in_item,
  slc_out_if.source                       out_item,
  input  logic                            cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  slc_pkg::ctl_cmd_t  cmd;
  slc_pkg::out_word_t res_word;
  logic               in_ready;
  logic               out_valid;

  // The controller sequences capture and execute and owns the result valid.
  slc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_item.ready),
    .cmd       (cmd)
  );

  // The datapath holds both queues, the link timer and retry state, and the
  // configuration registers.
  slc_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_item.data),
    .out_data  (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign in_item.ready  = in_ready;
  assign out_item.valid = out_valid;
  assign out_item.data  = res_word;

endmodule

// File: sv/slc_ctrl.sv
`timescale 1ns / 1ps

module slc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output slc_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  // The step commits only when the result register is free or being emptied.
  assign cmd.execute = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.execute) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/slc_datapath.sv
`timescale 1ns / 1ps

module slc_datapath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  slc_pkg::ctl_cmd_t                cmd,
  input  slc_pkg::in_word_t                in_data,
  output slc_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Slot numbers leave the block as three bits.
  function automatic logic [2:0] slot3(input logic [PW-1:0] p);
    logic [PW+2:0] w;
    w = {3'b000, p};
    return w[2:0];
  endfunction

  slc_pkg::in_word_t  item_r;
  slc_pkg::out_word_t res_r, res;

  slc_pkg::tx_entry_t tx_mem [QUEUE_DEPTH];
  slc_pkg::rx_entry_t rx_mem [QUEUE_DEPTH];

  logic [PW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [PW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  logic [7:0]    nack_run_r, nack_run_nxt;
  logic [15:0]   wait_ms_r, wait_ms_nxt;
  logic          dirty_r, dirty_nxt;

  logic [15:0]   timeout_r;
  logic [7:0]    max_tries_r, max_nack_r;

  logic               tx_we, rx_we;
  logic [PW-1:0]      tx_waddr, rx_waddr, rx_new_head;
  slc_pkg::tx_entry_t tx_wdata, tx_rd;
  slc_pkg::rx_entry_t rx_wdata, rx_rd;
  logic [15:0]        wait_tick;
  logic [7:0]         fails_inc;
  logic               handled, got_flag, flag_ack, drop;

  assign tx_rd     = tx_mem[tx_tail_r];
  assign rx_rd     = rx_mem[rx_tail_r];
  assign wait_tick = (item_r.ms_tick && (wait_ms_r != slc_pkg::WAIT_MAX)) ?
                     wait_ms_r + 16'd1 : wait_ms_r;
  assign fails_inc = (tx_rd.fails != slc_pkg::FAILS_MAX) ? tx_rd.fails + 8'd1 : tx_rd.fails;
  assign out_data  = res_r;

  always_comb begin
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    tx_count_nxt = tx_count_r;
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    rx_count_nxt = rx_count_r;
    nack_run_nxt = nack_run_r;
    wait_ms_nxt  = wait_ms_r;
    dirty_nxt    = dirty_r;
    res          = '0;
    tx_we        = 1'b0;
    tx_waddr     = tx_tail_r;
    tx_wdata     = tx_rd;
    rx_we        = 1'b0;
    rx_waddr     = rx_head_r;
    rx_wdata     = '0;
    rx_new_head  = rx_head_r;
    handled      = 1'b0;
    got_flag     = 1'b0;
    flag_ack     = 1'b0;
    drop         = 1'b0;

    case (slc_pkg::op_t'(item_r.op))
      slc_pkg::OP_POLL: begin
        wait_ms_nxt = wait_tick;
        if (item_r.frame_ready) begin
          if (item_r.frame_valid) begin
            nack_run_nxt = '0;
            if (item_r.frame_header <= slc_pkg::HDR_CONFIG) begin
              // Store into the receive ring, overwriting the oldest when full.
              handled = 1'b1;
              if (rx_count_r != '0) begin
                rx_new_head = ring_next(rx_head_r);
                if (rx_new_head == rx_tail_r) begin
                  rx_tail_nxt = ring_next(rx_tail_r);
                end else begin
                  rx_count_nxt = rx_count_r + 1'b1;
                end
              end else begin
                rx_count_nxt = rx_count_r + 1'b1;
              end
              rx_head_nxt       = rx_new_head;
              rx_we             = 1'b1;
              rx_waddr          = rx_new_head;
              rx_wdata.msg_type = item_r.frame_header[1:0];
              rx_wdata.len      = item_r.frame_length;
              res.link_action   = slc_pkg::ACT_ACK;
              res.rx_store      = 1'b1;
              res.rx_slot       = slot3(rx_new_head);
              dirty_nxt         = 1'b1;
            end else if (item_r.frame_header == slc_pkg::HDR_FLAGS) begin
              got_flag = 1'b1;
              flag_ack = item_r.flag_is_ack;
            end
          end else if (nack_run_r < max_nack_r) begin
            handled         = 1'b1;
            nack_run_nxt    = nack_run_r + 8'd1;
            res.link_action = slc_pkg::ACT_NACK;
            dirty_nxt       = 1'b1;
          end
        end

        if (!handled && (tx_count_r != '0)) begin
          if (!tx_rd.sent) begin
            tx_we           = 1'b1;
            tx_wdata.sent   = 1'b1;
            res.link_action = dirty_r ? slc_pkg::ACT_SEND : slc_pkg::ACT_RESEND;
            res.link_type   = tx_rd.msg_type;
            res.link_slot   = slot3(tx_tail_r);
            res.link_length = tx_rd.len;
            dirty_nxt       = 1'b0;
            nack_run_nxt    = '0;
            wait_ms_nxt     = '0;
          end else if (got_flag && flag_ack) begin
            drop = 1'b1;
          end else if (got_flag || (wait_tick >= timeout_r)) begin
            // One failure against the head message.
            tx_we          = 1'b1;
            tx_wdata.fails = fails_inc;
            if (tx_rd.retry && (fails_inc < max_tries_r)) begin
              tx_wdata.sent = 1'b0;
            end else begin
              drop = 1'b1;
            end
          end
        end

        if (drop) begin
          tx_count_nxt = tx_count_r - 1'b1;
          if (tx_count_r != CNT_ONE) begin
            tx_tail_nxt = ring_next(tx_tail_r);
          end
          dirty_nxt = 1'b1;
        end
      end

      slc_pkg::OP_ENQ: begin
        if (tx_count_r != CNT_FULL) begin
          tx_we = 1'b1;
          if (tx_count_r != '0) begin
            tx_waddr = ring_next(tx_head_r);
          end else begin
            tx_waddr = tx_head_r;
          end
          tx_head_nxt       = tx_waddr;
          tx_wdata.sent     = 1'b0;
          tx_wdata.retry    = (item_r.msg_type == slc_pkg::MSG_ALARM) ||
                              (item_r.msg_type == slc_pkg::MSG_CONFIG);
          tx_wdata.fails    = '0;
          tx_wdata.msg_type = item_r.msg_type;
          tx_wdata.len      = item_r.msg_length;
          tx_count_nxt      = tx_count_r + 1'b1;
          res.accepted      = 1'b1;
          res.enq_slot      = slot3(tx_waddr);
        end
      end

      slc_pkg::OP_READ: begin
        if (rx_count_r != '0) begin
          res.accepted  = 1'b1;
          res.rx_slot   = slot3(rx_tail_r);
          res.rx_type   = rx_rd.msg_type;
          res.rx_length = rx_rd.len;
          rx_count_nxt  = rx_count_r - 1'b1;
          if (rx_count_r != CNT_ONE) begin
            rx_tail_nxt = ring_next(rx_tail_r);
          end
        end
      end

      default: begin
        res = '0;
      end
    endcase
  end

  // Captured item, result word and queue memories; payload only, no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.execute) begin
      res_r <= res;
    end
    if (cmd.execute && tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    if (cmd.execute && rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      tx_count_r <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      rx_count_r <= '0;
      nack_run_r <= '0;
      wait_ms_r  <= '0;
      dirty_r    <= 1'b1;
    end else if (cmd.execute) begin
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      rx_count_r <= rx_count_nxt;
      nack_run_r <= nack_run_nxt;
      wait_ms_r  <= wait_ms_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= slc_pkg::TIMEOUT_RST;
      max_tries_r <= slc_pkg::MAX_TRIES_RST;
      max_nack_r  <= slc_pkg::MAX_NACK_RST;
    end else if (cfg_we) begin
      if (cfg_index == slc_pkg::CFG_TIMEOUT) begin
        timeout_r <= cfg_wdata;
      end else if (cfg_index == slc_pkg::CFG_MAX_TRIES) begin
        max_tries_r <= cfg_wdata[7:0];
      end else if (cfg_index == slc_pkg::CFG_MAX_NACK) begin
        max_nack_r <= cfg_wdata[7:0];
      end
    end
  end

endmodule
